[hw/rtl/rhsv_pkg.sv]
// Shared package for the RGB to HSV pixel unit.
// Holds default widths, the queue depth and the queue status type.
// No dependencies.
package rhsv_pkg;

    localparam int CHANNEL_BITS_DEF  = 8;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

[hw/rtl/rhsv_front.sv]
// Front end of the RGB to HSV pixel unit: finds max, min and chroma, picks the
// hue sector and forms the dividends and divisors for the back end.
// Depends on rhsv_pkg.
module rhsv_front
    import rhsv_pkg::*;
#(
    parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int HNW = CHANNEL_BITS + 3,
    localparam int IW  = 3 * CHANNEL_BITS + FRACTION_BITS + 2 * HNW
)
(
    input  logic [CHANNEL_BITS-1:0] red,
    input  logic [CHANNEL_BITS-1:0] green,
    input  logic [CHANNEL_BITS-1:0] blue,
    output logic [IW-1:0]           item
);

    localparam int SNW = CHANNEL_BITS + FRACTION_BITS;

    logic [CHANNEL_BITS-1:0] vmax;
    logic [CHANNEL_BITS-1:0] vmin;
    logic [CHANNEL_BITS-1:0] chroma;
    logic [CHANNEL_BITS-1:0] sat_den;
    logic [SNW-1:0]          sat_num;
    logic [HNW-1:0]          r_x;
    logic [HNW-1:0]          g_x;
    logic [HNW-1:0]          b_x;
    logic [HNW-1:0]          c_x;
    logic [HNW-1:0]          c6;
    logic [HNW-1:0]          hue_num;
    logic [HNW-1:0]          hue_den;

    always_comb
    begin
        vmax = red;
        vmin = red;
        if (green > vmax) vmax = green;
        if (blue > vmax)  vmax = blue;
        if (green < vmin) vmin = green;
        if (blue < vmin)  vmin = blue;
    end

    assign chroma = vmax - vmin;

    // chroma * (2^F - 1) written as a shift and a subtract.
    assign sat_num = {chroma, {FRACTION_BITS{1'b0}}} - SNW'(chroma);
    assign sat_den = (vmax == '0) ? CHANNEL_BITS'(1) : vmax;

    assign r_x = HNW'(red);
    assign g_x = HNW'(green);
    assign b_x = HNW'(blue);
    assign c_x = HNW'(chroma);
    assign c6  = (c_x << 2) + (c_x << 1);

    // Hue numerator in sixths of a turn scaled by chroma; lies in 0 .. 6C-1.
    always_comb
    begin
        if (vmax == red) begin
            if (green >= blue)
                hue_num = g_x - b_x;
            else
                hue_num = c6 - (b_x - g_x);
        end
        else if (vmax == green) begin
            hue_num = (c_x << 1) + b_x - r_x;
        end
        else begin
            hue_num = (c_x << 2) + r_x - g_x;
        end
    end

    // A gray pixel has a zero numerator; a divisor of one keeps the quotient zero.
    assign hue_den = (chroma == '0) ? HNW'(1) : c6;

    assign item = {vmax, sat_den, sat_num, hue_num, hue_den};

endmodule

[hw/rtl/rhsv_queue.sv]
// Short item queue between the front and back ends of the pixel unit.
// Flop-based, fall-through read. Depends on rhsv_pkg.
module rhsv_queue
    import rhsv_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head,
    output q_status_t    status
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[hw/rtl/rhsv_div_pipe.sv]
// Pipelined restoring divider: one quotient bit per stage, QW stages.
// The initial remainder must be below the divisor. Depends on rhsv_pkg.
module rhsv_div_pipe
    import rhsv_pkg::*;
#(
    parameter int DW = 8,
    parameter int QW = 16
)
(
    input  logic          clk,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] low_in,
    input  logic [DW-1:0] den_in,
    output logic [QW-1:0] quo
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] den_reg [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW-1:0] rem_i;
        logic [QW-1:0] low_i;
        logic [QW-1:0] quo_i;
        logic [DW-1:0] den_i;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (s == 0) begin : g_first
            assign rem_i = rem_in;
            assign low_i = low_in;
            assign quo_i = '0;
            assign den_i = den_in;
        end
        else begin : g_rest
            assign rem_i = rem_reg[s-1];
            assign low_i = low_reg[s-1];
            assign quo_i = quo_reg[s-1];
            assign den_i = den_reg[s-1];
        end

        assign trial    = {rem_i, low_i[QW-1]};
        assign diff     = trial - {1'b0, den_i};
        assign ge       = (trial >= {1'b0, den_i});
        assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            low_reg[s] <= low_i << 1;
            quo_reg[s] <= {quo_i[QW-2:0], ge};
            den_reg[s] <= den_i;
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

[hw/rtl/rhsv_back.sv]
// Back end of the RGB to HSV pixel unit: two pipelined dividers for hue and
// saturation with matching valid and brightness delay lines.
// Depends on rhsv_pkg and rhsv_div_pipe.
module rhsv_back
    import rhsv_pkg::*;
#(
    parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int HNW = CHANNEL_BITS + 3,
    localparam int IW  = 3 * CHANNEL_BITS + FRACTION_BITS + 2 * HNW
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  logic [IW-1:0]            item,
    output logic                     done,
    output logic [FRACTION_BITS-1:0] hue,
    output logic [FRACTION_BITS-1:0] saturation,
    output logic [CHANNEL_BITS-1:0]  brightness
);

    localparam int SNW    = CHANNEL_BITS + FRACTION_BITS;
    localparam int QW_LEN = FRACTION_BITS;

    logic [CHANNEL_BITS-1:0] vmax;
    logic [CHANNEL_BITS-1:0] sat_den;
    logic [SNW-1:0]          sat_num;
    logic [HNW-1:0]          hue_num;
    logic [HNW-1:0]          hue_den;
    logic [QW_LEN-1:0]       vld_reg;
    logic [CHANNEL_BITS-1:0] brt_reg [QW_LEN];

    assign {vmax, sat_den, sat_num, hue_num, hue_den} = item;

    rhsv_div_pipe #(
        .DW (CHANNEL_BITS),
        .QW (FRACTION_BITS)
    ) u_sat_div (
        .clk    (clk),
        .rem_in (sat_num[SNW-1:FRACTION_BITS]),
        .low_in (sat_num[FRACTION_BITS-1:0]),
        .den_in (sat_den),
        .quo    (saturation)
    );

    rhsv_div_pipe #(
        .DW (HNW),
        .QW (FRACTION_BITS)
    ) u_hue_div (
        .clk    (clk),
        .rem_in (hue_num),
        .low_in ('0),
        .den_in (hue_den),
        .quo    (hue)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[QW_LEN-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        brt_reg[0] <= vmax;
        for (int i = 1; i < QW_LEN; i++)
            brt_reg[i] <= brt_reg[i-1];
    end

    assign done       = vld_reg[QW_LEN-1];
    assign brightness = brt_reg[QW_LEN-1];

endmodule

[hw/rtl/rgb_to_hsv_pixel_unit.sv]
// Top level of the RGB to HSV pixel unit.
// Depends on rhsv_pkg, rhsv_front, rhsv_queue, rhsv_div_pipe and rhsv_back.
//
// Usage: an item is one RGB pixel on red, green and blue. It is taken at a
// rising clock edge where start is high and busy is low. Each item yields
// exactly one result: hue and saturation as unsigned fractions of
// FRACTION_BITS bits and brightness as the channel maximum. A result is shown
// on hue, saturation and brightness for one cycle with done high; the
// receiver cannot hold it off.
//
// Throughput is one item per clock. The front end classifies a pixel
// combinationally and writes it into a two-entry queue; the back end pops
// an item whenever the queue holds one, into two pipelined dividers that
// resolve one quotient bit per stage. From the accepting edge, an item is
// held in a queue slot and then passes through the divider stages, whose
// depth sets the delay to its result. Since the back end never stalls, the
// queue holds at most one item and busy stays low in normal operation; it
// rises only if the queue were full.
// Reset clears the queue and the valid pipeline; items in flight are dropped
// and no done strobe appears until a new item is accepted.
module rgb_to_hsv_pixel_unit
    import rhsv_pkg::*;
#(
    parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CHANNEL_BITS-1:0]  red,
    input  logic [CHANNEL_BITS-1:0]  green,
    input  logic [CHANNEL_BITS-1:0]  blue,
    output logic                     done,
    output logic [FRACTION_BITS-1:0] hue,
    output logic [FRACTION_BITS-1:0] saturation,
    output logic [CHANNEL_BITS-1:0]  brightness
);

    localparam int HNW = CHANNEL_BITS + 3;
    localparam int IW  = 3 * CHANNEL_BITS + FRACTION_BITS + 2 * HNW;
    localparam int LAT = FRACTION_BITS + 1;

    logic [IW-1:0] front_item;
    logic [IW-1:0] head_item;
    q_status_t     q_status;
    logic          accept;
    logic          take;

    assign busy   = q_status.full;
    assign accept = start && !busy;

    // The back end drains the queue whenever it holds an item.
    assign take = !q_status.empty;

    rhsv_front #(
        .CHANNEL_BITS  (CHANNEL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .red   (red),
        .green (green),
        .blue  (blue),
        .item  (front_item)
    );

    rhsv_queue #(
        .W (IW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_item),
        .pop       (take),
        .head      (head_item),
        .status    (q_status)
    );

    rhsv_back #(
        .CHANNEL_BITS  (CHANNEL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .item       (head_item),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    // Every accepted item comes out as exactly one done strobe, and nothing else does.
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start && !busy && rst_n, LAT))
        else $error("done strobe does not match an accepted item");

    // The back end pops an item whenever the queue holds one, so the queue never fills.
    a_never_full : assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("item queue filled up");

    // A black pixel has zero hue and zero saturation.
    a_black : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (brightness == '0)) |-> ((hue == '0) && (saturation == '0)))
        else $error("black pixel gave nonzero hue or saturation");

endmodule
